// ===== sv/cbe_pkg.sv =====
// types and constants shared by the cbor head encoder modules
package cbe_pkg;

	// request codes on req_type
	typedef enum logic [2:0] {
		REQ_UINT    = 3'd0,
		REQ_BSTR    = 3'd1,
		REQ_TSTR    = 3'd2,
		REQ_ARRAY   = 3'd3,
		REQ_BYTE    = 3'd4,
		REQ_FINISH  = 3'd5,
		REQ_RESTART = 3'd6
	} req_t;

	// cbor major types
	localparam logic [2:0] MAJOR_UINT  = 3'd0;
	localparam logic [2:0] MAJOR_BSTR  = 3'd2;
	localparam logic [2:0] MAJOR_TSTR  = 3'd3;
	localparam logic [2:0] MAJOR_ARRAY = 3'd4;

	// additional info codes for explicit arguments
	localparam logic [4:0] AI_ARG1 = 5'd24;
	localparam logic [4:0] AI_ARG2 = 5'd25;
	localparam logic [4:0] AI_ARG4 = 5'd26;
	localparam logic [4:0] AI_ARG8 = 5'd27;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	// one unit of work for the serializer: a head, a payload byte or a status
	typedef struct packed {
		logic        is_status;
		logic        status;
		logic [3:0]  nbytes;   // 1 to 9 words to emit
		logic [7:0]  first;    // initial byte, payload byte, or zero
		logic [63:0] arg;      // argument bytes, left aligned, big-endian
		logic [15:0] base;     // offset of the first word
		logic [15:0] len;      // used length reported by finish
	} job_t;

endpackage

// ===== sv/cbe_front.sv =====
// front end: accepts requests, checks room, keeps length and error state
module cbe_front
	import cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [63:0] value,
	input  logic [7:0]  data_byte,
	input  logic        queue_full,
	output logic        push,
	output job_t        push_job
);

	logic [15:0] cap_q;
	logic [15:0] used_q;
	logic        err_q;

	logic        accept;
	logic [15:0] room;
	logic [15:0] room_after;
	logic [3:0]  argn;
	logic [3:0]  nhead;
	logic [4:0]  ai;
	logic [2:0]  major;
	logic [63:0] arg_al;
	logic        fits;
	logic        too_long;
	logic        is_string;
	logic [15:0] used_d;
	logic        err_d;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// room left in the buffer, zero if capacity dropped below the used length
	assign room = (cap_q > used_q) ? (cap_q - used_q) : 16'd0;

	// shortest canonical argument size
	always_comb begin
		if (value < 64'd24) begin
			ai     = value[4:0];
			argn   = 4'd0;
			arg_al = 64'd0;
		end else if (value[63:8] == 56'd0) begin
			ai     = AI_ARG1;
			argn   = 4'd1;
			arg_al = {value[7:0], 56'd0};
		end else if (value[63:16] == 48'd0) begin
			ai     = AI_ARG2;
			argn   = 4'd2;
			arg_al = {value[15:0], 48'd0};
		end else if (value[63:32] == 32'd0) begin
			ai     = AI_ARG4;
			argn   = 4'd4;
			arg_al = {value[31:0], 32'd0};
		end else begin
			ai     = AI_ARG8;
			argn   = 4'd8;
			arg_al = value;
		end
	end

	assign nhead      = argn + 4'd1;
	assign fits       = {12'd0, nhead} <= room;
	assign room_after = room - {12'd0, nhead};
	assign too_long   = (value[63:16] != 48'd0) || (value[15:0] > room_after);
	assign is_string  = (req_type == REQ_BSTR) || (req_type == REQ_TSTR);

	// major type decoder
	always_comb begin
		unique case (req_type)
			REQ_BSTR:  major = MAJOR_BSTR;
			REQ_TSTR:  major = MAJOR_TSTR;
			REQ_ARRAY: major = MAJOR_ARRAY;
			default:   major = MAJOR_UINT;
		endcase
	end

	// request decoder: next state and the job to queue
	always_comb begin
		used_d   = used_q;
		err_d    = err_q;
		push     = 1'b0;
		push_job = '0;
		unique case (req_type)
			REQ_UINT, REQ_BSTR, REQ_TSTR, REQ_ARRAY: begin
				if (!err_q) begin
					if (!fits) begin
						err_d = 1'b1;
					end else begin
						push            = accept;
						push_job.nbytes = nhead;
						push_job.first  = {major, ai};
						push_job.arg    = arg_al;
						push_job.base   = used_q;
						used_d          = used_q + {12'd0, nhead};
						if (is_string && too_long) begin
							err_d = 1'b1;
						end
					end
				end
			end
			REQ_BYTE: begin
				if (!err_q) begin
					if (room == 16'd0) begin
						err_d = 1'b1;
					end else begin
						push            = accept;
						push_job.nbytes = 4'd1;
						push_job.first  = data_byte;
						push_job.base   = used_q;
						used_d          = used_q + 16'd1;
					end
				end
			end
			REQ_FINISH: begin
				push               = accept;
				push_job.nbytes    = 4'd1;
				push_job.is_status = 1'b1;
				push_job.status    = err_q;
				push_job.len       = used_q;
			end
			REQ_RESTART: begin
				used_d = 16'd0;
				err_d  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// capacity register and encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAPACITY_RESET;
			used_q <= 16'd0;
			err_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				used_q <= used_d;
				err_q  <= err_d;
			end
		end
	end

endmodule

// ===== sv/cbe_queue.sv =====
// small job queue between front end and serializer
module cbe_queue
	import cbe_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head_job,
	output logic full,
	output logic nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign nonempty = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head_job = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/cbe_back.sv =====
// serializer: walks each queued job one word per cycle into the output register while out_ready does not stall it
module cbe_back
	import cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [15:0] offset,
	output logic        last,
	output logic        is_status,
	output logic        status,
	output logic [15:0] length
);

	logic [3:0]  idx_q;
	logic        load;
	logic        final_word;
	logic [5:0]  sh;
	logic [63:0] shifted;
	logic [7:0]  word;

	assign load       = job_valid && (!out_valid || out_ready);
	assign final_word = idx_q == (job.nbytes - 4'd1);
	assign pop        = load && final_word;

	// pick the current word of the job
	assign sh      = {3'(idx_q - 4'd1), 3'b000};
	assign shifted = job.arg << sh;
	assign word    = (idx_q == 4'd0) ? job.first : shifted[63:56];

	// word index within the job and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 4'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_word ? 4'd0 : idx_q + 4'd1;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte  <= word;
			offset    <= job.base + {12'd0, idx_q};
			last      <= final_word;
			is_status <= job.is_status;
			status    <= job.status;
			length    <= job.len;
		end
	end

endmodule

// ===== sv/cbor_head_encoder_unit.sv =====
// cbor canonical head encoder top level
//
// Requests enter on in_valid/in_ready with req_type, value and data_byte.
// Heads for unsigned integers, strings and arrays come out as 1, 2, 3, 5
// or 9 words on out_valid/out_ready, payload bytes as one word each, and
// finish as one status word with the used length. The last word of each
// request carries last. Requests that emit nothing (restart, overflow,
// anything but finish after an error) only update state.
// The front end checks room and updates length and error in the cycle a
// request is accepted, then queues a job; the serializer emits one word
// per cycle unless out_ready stalls it. The first word of a request
// passes through the job queue (QUEUE_DEPTH entries) into the output
// register. A request is accepted every cycle while the queue has space;
// a head of n bytes takes n output words.
// Reset sets capacity to 65535 and clears length, error and the queue.
// When the receiver stalls, the output word holds, the queue fills and
// then in_ready drops. cfg_we writes capacity; write it only when idle.
module cbor_head_encoder_unit
	import cbe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [63:0] value,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [15:0] offset,
	output logic        last,
	output logic        is_status,
	output logic        status,
	output logic [15:0] length
);

	logic queue_full;
	logic queue_nonempty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	// request classification and state
	cbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.value      (value),
		.data_byte  (data_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	// job queue
	cbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (queue_full),
		.nonempty (queue_nonempty)
	);

	// word serializer
	cbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_nonempty),
		.job       (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.offset    (offset),
		.last      (last),
		.is_status (is_status),
		.status    (status),
		.length    (length)
	);

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the cbor head encoder: predicts every word and compares
module tb_top;
	import cbe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 40;
	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	// one expected output word
	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] off;
		logic        lst;
		logic        stat_word;
		logic        stat;
		logic [15:0] len;
	} enc_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  req_type = REQ_UINT;
	logic [63:0] value = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic [15:0] offset;
	logic        last;
	logic        is_status;
	logic        status;
	logic [15:0] length;

	// encoder state as predicted
	logic [15:0] buf_capacity = CAPACITY_RESET;
	logic [15:0] buf_used = '0;
	logic        buf_overflow = 1'b0;
	enc_word_t   expected_words[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 1;
	bit gaps_on = 1'b0;
	bit offering = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int mode_left = 0;
	int phase_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;

	cbor_head_encoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.offset    (offset),
		.last      (last),
		.is_status (is_status),
		.status    (status),
		.length    (length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic int unsigned room_left();
		return (buf_capacity > buf_used) ? int'(buf_capacity) - int'(buf_used) : 0;
	endfunction

	task automatic push_word(input logic [7:0] d, input logic [15:0] off, input logic lst,
			input logic stat_word, input logic stat, input logic [15:0] len);
		enc_word_t w;
		w.data = d;
		w.off = off;
		w.lst = lst;
		w.stat_word = stat_word;
		w.stat = stat;
		w.len = len;
		expected_words.push_back(w);
	endtask

	// shortest canonical head, all or nothing
	task automatic predict_head(input logic [2:0] major, input logic [63:0] v);
		logic [4:0] ai;
		int unsigned nargs;
		int unsigned i;
		logic [63:0] shifted;
		if (v < 64'd24) begin
			ai = v[4:0];
			nargs = 0;
		end else if (v <= 64'hFF) begin
			ai = AI_ARG1;
			nargs = 1;
		end else if (v <= 64'hFFFF) begin
			ai = AI_ARG2;
			nargs = 2;
		end else if (v <= 64'hFFFF_FFFF) begin
			ai = AI_ARG4;
			nargs = 4;
		end else begin
			ai = AI_ARG8;
			nargs = 8;
		end
		if (buf_overflow)
			return;
		if (nargs + 1 > room_left()) begin
			buf_overflow = 1'b1;
			return;
		end
		push_word({major, ai}, buf_used, nargs == 0, 1'b0, 1'b0, 16'd0);
		for (i = 0; i < nargs; i++) begin
			shifted = v >> (8 * (nargs - 1 - i));
			push_word(shifted[7:0], buf_used + 16'(i + 1), i + 1 == nargs, 1'b0, 1'b0, 16'd0);
		end
		buf_used = buf_used + 16'(nargs + 1);
	endtask

	task automatic encode_request(input logic [2:0] code, input logic [63:0] v,
			input logic [7:0] d);
		case (code)
			REQ_UINT: predict_head(MAJOR_UINT, v);
			REQ_BSTR, REQ_TSTR: begin
				predict_head((code == REQ_BSTR) ? MAJOR_BSTR : MAJOR_TSTR, v);
				// declared payload must fit behind the head
				if (!buf_overflow && v > 64'(room_left()))
					buf_overflow = 1'b1;
			end
			REQ_ARRAY: predict_head(MAJOR_ARRAY, v);
			REQ_BYTE: begin
				if (!buf_overflow) begin
					if (room_left() == 0) begin
						buf_overflow = 1'b1;
					end else begin
						push_word(d, buf_used, 1'b1, 1'b0, 1'b0, 16'd0);
						buf_used = buf_used + 16'd1;
					end
				end
			end
			REQ_FINISH: push_word(8'd0, 16'd0, 1'b1, 1'b1, buf_overflow, buf_used);
			REQ_RESTART: begin
				buf_used = '0;
				buf_overflow = 1'b0;
			end
			default: ;
		endcase
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
				got, want);
		mismatch_count++;
	endtask

	task automatic check_word();
		enc_word_t w;
		if (expected_words.size() == 0) begin
			report_mismatch("word with nothing pending, out_byte", out_byte, 0);
			return;
		end
		w = expected_words.pop_front();
		if (out_byte !== w.data)
			report_mismatch("out_byte", out_byte, w.data);
		if (offset !== w.off)
			report_mismatch("offset", offset, w.off);
		if (last !== w.lst)
			report_mismatch("last", last, w.lst);
		if (is_status !== w.stat_word)
			report_mismatch("is_status", is_status, w.stat_word);
		if (status !== w.stat)
			report_mismatch("status", status, w.stat);
		if (length !== w.len)
			report_mismatch("length", length, w.len);
	endtask

	// sample both handshakes and the register write at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_word();
			if (cfg_we)
				buf_capacity = cfg_wdata;
			if (in_valid && in_ready)
				encode_request(req_type, value, data_byte);
		end
	end

	// receiver: changing stall patterns plus an optional long hold
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 80);
		end
		mode_left--;
		phase_tick++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= (phase_tick % 3 != 0);
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------

	task automatic stop_offer();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// offer one word and hold it until accepted; gaps between bursts when gaps_on is set
	task automatic send_word(input logic [2:0] code, input logic [63:0] v,
			input logic [7:0] d);
		in_valid <= 1'b1;
		offering = 1'b1;
		req_type <= code;
		value <= v;
		data_byte <= d;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				stop_offer();
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end
		end
	endtask

	// sender pauses until every pending word has come out
	task automatic wait_idle();
		stop_offer();
		// wait so the last accepted word is already predicted
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] cap);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// argument spread over every head size, boundaries included
	function automatic logic [63:0] rand_arg();
		logic [63:0] edges[9];
		edges = '{64'd23, 64'd24, 64'hFF, 64'h100, 64'hFFFF, 64'h1_0000, 64'hFFFF_FFFF,
			64'h1_0000_0000, ALL_ONES};
		case ($urandom_range(0, 5))
			0: return 64'($urandom_range(0, 23));
			1: return 64'($urandom_range(24, 255));
			2: return 64'($urandom_range(256, 65535));
			3: return 64'($urandom_range(65536, 32'hFFFF_FFFF));
			4: return {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
			default: return edges[$urandom_range(0, 8)];
		endcase
	endfunction

	function automatic logic [63:0] rand_noise();
		return {32'($urandom), 32'($urandom)};
	endfunction

	// one record: often a string with its payload (at most 16 bytes), else a head or a control
	task automatic send_record();
		int pick;
		int n;
		int i;
		logic [63:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if ($urandom_range(0, 7) == 0)
				len = rand_arg();
			else
				len = 64'($urandom_range(0, 10));
			send_word($urandom_range(0, 1) ? REQ_BSTR : REQ_TSTR, len, 8'($urandom));
			n = (len > 64'd16) ? 16 : int'(len);
			for (i = 0; i < n; i++)
				send_word(REQ_BYTE, rand_noise(), 8'($urandom));
		end else if (pick < 65) begin
			send_word(REQ_UINT, rand_arg(), 8'($urandom));
		end else if (pick < 75) begin
			send_word(REQ_ARRAY, rand_arg(), 8'($urandom));
		end else if (pick < 82) begin
			send_word(REQ_BYTE, rand_noise(), 8'($urandom));
		end else if (pick < 91) begin
			send_word(REQ_FINISH, rand_noise(), 8'($urandom));
		end else if (pick < 97) begin
			send_word(REQ_RESTART, rand_noise(), 8'($urandom));
		end else begin
			send_word(REQ_UNUSED, rand_noise(), 8'($urandom));
		end
	endtask

	// ---------------- tests ----------------

	// every head size and major type at reset capacity, no gaps
	task automatic test_head_sizes();
		gaps_on = 1'b0;
		send_word(REQ_UINT, 64'd0, 8'h00);
		send_word(REQ_UINT, 64'd23, 8'hFF);
		send_word(REQ_UINT, 64'd24, 8'h00);
		send_word(REQ_UINT, 64'hFF, 8'h00);
		send_word(REQ_UINT, 64'h100, 8'h00);
		send_word(REQ_UINT, 64'hFFFF, 8'h00);
		send_word(REQ_UINT, 64'h1_0000, 8'h00);
		send_word(REQ_UINT, 64'hFFFF_FFFF, 8'h00);
		send_word(REQ_ARRAY, 64'h1_0000_0000, 8'h00);
		send_word(REQ_ARRAY, ALL_ONES, 8'h00);
		// zero-length string is just its head
		send_word(REQ_BSTR, 64'd0, 8'h00);
		send_word(REQ_TSTR, 64'd2, 8'h00);
		send_word(REQ_BYTE, 64'd0, 8'h00);
		send_word(REQ_BYTE, ALL_ONES, 8'hFF);
		send_word(REQ_UNUSED, ALL_ONES, 8'hFF);
		send_word(REQ_FINISH, 64'd0, 8'h00);
		send_word(REQ_RESTART, 64'd0, 8'h00);
	endtask

	// heads and payload that do not fit, sticky error, lowered capacity
	task automatic test_overflow();
		gaps_on = 1'b0;
		set_capacity(16'd10);
		send_word(REQ_UINT, ALL_ONES, 8'h00);
		send_word(REQ_UINT, 64'd24, 8'h00);
		send_word(REQ_BYTE, 64'd0, 8'h5A);
		send_word(REQ_FINISH, 64'd0, 8'h00);
		send_word(REQ_RESTART, 64'd0, 8'h00);
		// string head fits, declared payload does not
		send_word(REQ_TSTR, 64'd20, 8'h00);
		send_word(REQ_FINISH, 64'd0, 8'h00);
		send_word(REQ_RESTART, 64'd0, 8'h00);
		set_capacity(16'd1);
		send_word(REQ_BYTE, 64'd0, 8'hA5);
		send_word(REQ_BYTE, 64'd0, 8'h3C);
		send_word(REQ_FINISH, 64'd0, 8'h00);
		send_word(REQ_RESTART, 64'd0, 8'h00);
		send_word(REQ_BYTE, 64'd0, 8'h11);
		// capacity drops below the used length
		set_capacity(16'd0);
		send_word(REQ_BYTE, 64'd0, 8'h22);
		send_word(REQ_FINISH, 64'd0, 8'h00);
		send_word(REQ_RESTART, 64'd0, 8'h00);
		send_word(REQ_UINT, 64'd0, 8'h00);
		send_word(REQ_FINISH, 64'd0, 8'h00);
		send_word(REQ_RESTART, 64'd0, 8'h00);
	endtask

	task automatic test_random_stream(input logic [15:0] cap, input int count);
		int target;
		set_capacity(cap);
		gaps_on = 1'b1;
		burst_left = $urandom_range(1, 20);
		send_word(REQ_RESTART, rand_noise(), 8'($urandom));
		target = items_sent + count;
		while (items_sent < target)
			send_record();
		send_word(REQ_FINISH, rand_noise(), 8'($urandom));
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		int i;
		set_capacity(CAPACITY_RESET);
		gaps_on = 1'b0;
		send_word(REQ_RESTART, 64'd0, 8'h00);
		hold_request = 150;
		send_word(REQ_UINT, ALL_ONES, 8'h00);
		send_word(REQ_BSTR, 64'd24, 8'h00);
		for (i = 0; i < 24; i++)
			send_word(REQ_BYTE, 64'd0, 8'($urandom));
		send_word(REQ_FINISH, 64'd0, 8'h00);
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_head_sizes();
		test_overflow();
		test_backpressure();
		test_random_stream(CAPACITY_RESET, 35);
		test_random_stream(16'd0, 5);
		test_random_stream(16'($urandom_range(1, 60)), 25);
		test_random_stream(16'($urandom_range(100, 2000)), 30);
		test_random_stream(16'($urandom_range(2, 12)), 10);
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
